/* hdl/cartridge_bank_switch_mapper_assert.svh */
// Assertion macros shared by the mapper's checker.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define CBSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CBSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CBSM_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cbsm_pkg.sv */
// Package with the mapper's types, widths and constants.
package cbsm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int BANK_W     = 8;
  localparam int ROM_W      = 21;
  localparam int OFFSET_W   = 20;
  localparam int BANK_BYTES = 16384;
  localparam int BANK_SHIFT = $clog2(BANK_BYTES);
  localparam int FULL_OFS_W = BANK_W + BANK_SHIFT;
  localparam int MAXBANK_W  = ROM_W - BANK_SHIFT;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TYPE_W     = 3;

  localparam logic [ROM_W-1:0] MAX_ROM_BYTES   = ROM_W'(1048576);
  localparam logic [ROM_W-1:0] SMALL_ROM_LIMIT = ROM_W'(65536);

  localparam logic [ADDR_W-1:0] SUPER_WIN_LO = 16'h8000;
  localparam logic [ADDR_W-1:0] SUPER_WIN_HI = 16'hC000;
  localparam logic [ADDR_W-1:0] ABS_WINDOW   = 16'h4000;
  localparam logic [ADDR_W-1:0] ACT_WINDOW   = 16'hA000;
  localparam logic [ADDR_W-1:0] ACT_ADDR_LO  = 16'hFF80;

  localparam logic [DATA_W-1:0] ABS_BANK_A = 8'd1;
  localparam logic [DATA_W-1:0] ABS_BANK_B = 8'd2;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_CART_TYPE = 1'b0;
  localparam logic REG_ROM_BYTES = 1'b1;

  typedef enum logic [TYPE_W-1:0] {
    CART_PLAIN      = 3'd0,
    CART_SUPER      = 3'd1,
    CART_SUPER_RAM  = 3'd2,
    CART_SUPER_ROM  = 3'd3,
    CART_LARGE      = 3'd4,
    CART_ABSOLUTE   = 3'd5,
    CART_ACTIVISION = 3'd6
  } cart_type_t;

  typedef struct packed {
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_data;
  } bus_item_t;

  typedef struct packed {
    logic                switched;
    logic [ADDR_W-1:0]   window_base;
    logic [OFFSET_W-1:0] rom_offset;
    logic [BANK_W-1:0]   current_bank;
  } map_item_t;

  typedef struct packed {
    cart_type_t       cart_type;
    logic [ROM_W-1:0] eff_size;
  } cfg_t;

endpackage

/* hdl/cbsm_if.sv */
// Valid/ready channel interfaces for bus writes and mapping results.
interface cbsm_bus_if;
  import cbsm_pkg::*;

  logic      valid;
  logic      ready;
  bus_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface cbsm_map_if;
  import cbsm_pkg::*;

  logic      valid;
  logic      ready;
  map_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

/* hdl/cbsm_cfg_regs.sv */
// Configuration registers behind the APB-style port.
module cbsm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbsm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbsm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbsm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output cbsm_pkg::cfg_t                  cfg
);
  import cbsm_pkg::*;

  cart_type_t       cart_type;
  logic [ROM_W-1:0] rom_bytes;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type <= CART_PLAIN;
      rom_bytes <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_CART_TYPE) begin
        cart_type <= cart_type_t'(pwdata[TYPE_W-1:0]);
      end else begin
        rom_bytes <= pwdata[ROM_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_ROM_BYTES) begin
      prdata = {{(CFG_DATA_W-ROM_W){1'b0}}, rom_bytes};
    end else begin
      prdata = {{(CFG_DATA_W-TYPE_W){1'b0}}, cart_type};
    end
  end

  // Images larger than the mapper's address range are treated as full size.
  assign cfg.cart_type = cart_type;
  assign cfg.eff_size  = (rom_bytes > MAX_ROM_BYTES) ? MAX_ROM_BYTES : rom_bytes;

endmodule

/* hdl/cbsm_decode.sv */
// Bank-switch decode of one registered bus write.
module cbsm_decode (
  input  cbsm_pkg::cfg_t                   cfg,
  input  cbsm_pkg::bus_item_t              item,
  input  logic [cbsm_pkg::BANK_W-1:0]      bank_reg,
  output cbsm_pkg::map_item_t              result
);
  import cbsm_pkg::*;

  logic [ADDR_W-1:0]     addr;
  logic [DATA_W-1:0]     data;
  logic [MAXBANK_W-1:0]  maxbank;
  logic                  in_super;
  logic                  req;
  logic [BANK_W-1:0]     bank;
  logic [ADDR_W-1:0]     window;
  logic                  small_rom;
  logic [BANK_W-1:0]     eff_bank;
  logic [FULL_OFS_W-1:0] offset;
  logic                  fits;
  logic                  switched;

  assign addr    = item.bus_address;
  assign data    = item.bus_data;
  assign maxbank = cfg.eff_size[ROM_W-1:BANK_SHIFT];
  assign in_super = (addr >= SUPER_WIN_LO) && (addr < SUPER_WIN_HI) &&
                    (data < DATA_W'(maxbank));

  always_comb begin
    req    = 1'b0;
    bank   = '0;
    window = '0;
    unique case (cfg.cart_type)
      CART_SUPER, CART_SUPER_RAM, CART_SUPER_ROM: begin
        req    = in_super;
        bank   = data;
        window = SUPER_WIN_LO;
      end
      CART_LARGE: begin
        req    = in_super;
        bank   = BANK_W'(data + 8'd1);
        window = SUPER_WIN_LO;
      end
      CART_ABSOLUTE: begin
        req    = (addr == SUPER_WIN_LO) && ((data == ABS_BANK_A) || (data == ABS_BANK_B));
        bank   = BANK_W'(data - 8'd1);
        window = ABS_WINDOW;
      end
      CART_ACTIVISION: begin
        req    = (addr >= ACT_ADDR_LO);
        bank   = {{(BANK_W-3){1'b0}}, addr[2:0]};
        window = ACT_WINDOW;
      end
      default: begin
        req    = 1'b0;
        bank   = '0;
        window = '0;
      end
    endcase
  end

  // Supercarts of 64 KB or less only decode the low two bank bits.
  assign small_rom = ((cfg.cart_type == CART_SUPER) || (cfg.cart_type == CART_SUPER_RAM) ||
                      (cfg.cart_type == CART_SUPER_ROM)) && (cfg.eff_size <= SMALL_ROM_LIMIT);
  assign eff_bank  = small_rom ? {{(BANK_W-2){1'b0}}, bank[1:0]} : bank;
  assign offset    = {eff_bank, {BANK_SHIFT{1'b0}}};
  assign fits      = offset < FULL_OFS_W'(cfg.eff_size);
  assign switched  = req && fits;

  assign result.switched     = switched;
  assign result.window_base  = switched ? window : '0;
  assign result.rom_offset   = switched ? offset[OFFSET_W-1:0] : '0;
  assign result.current_bank = switched ? bank : bank_reg;

endmodule

/* hdl/cartridge_bank_switch_mapper.sv */
// Cartridge bank-switch mapper top level. Every processor bus write presented on
// bus_write yields exactly one transaction on mapping, in order. The block takes
// one write per clock cycle while mapping is not stalled. A taken write is held
// in the input register, is decoded, and its result is held in the result
// register, which offers it on mapping until it is taken. The decode between
// those registers is combinational, and the bank register is updated as each
// result is registered, so the following write already sees it.
// Cartridge type and ROM size are written over the APB port at byte addresses 0
// and 4 and must only change while no write is in flight.
module cartridge_bank_switch_mapper (
  input  logic                            clk,
  input  logic                            rst,
  cbsm_bus_if.sink                        bus_write,
  cbsm_map_if.source                      mapping,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbsm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbsm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbsm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import cbsm_pkg::*;

  cfg_t              cfg;
  logic              in_valid;
  bus_item_t         in_item;
  logic              out_valid;
  map_item_t         out_item;
  logic [BANK_W-1:0] bank_reg;
  map_item_t         dec_result;
  logic              out_adv;
  logic              in_ready;

  cbsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbsm_decode u_decode (
    .cfg      (cfg),
    .item     (in_item),
    .bank_reg (bank_reg),
    .result   (dec_result)
  );

  assign out_adv         = !out_valid || mapping.ready;
  assign in_ready        = !in_valid || out_adv;
  assign bus_write.ready = in_ready;
  assign mapping.valid   = out_valid;
  assign mapping.data    = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      bank_reg  <= '0;
    end else begin
      if (in_ready) begin
        in_valid <= bus_write.valid;
      end
      if (out_adv) begin
        out_valid <= in_valid;
        if (in_valid) begin
          bank_reg <= dec_result.current_bank;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && bus_write.valid) begin
      in_item <= bus_write.data;
    end
    if (out_adv && in_valid) begin
      out_item <= dec_result;
    end
  end

endmodule

/* hdl/cbsm_checker.sv */
// Port-level assertions for the mapper, bound to the top level.
`include "cartridge_bank_switch_mapper_assert.svh"

module cbsm_checker (
  input logic                clk,
  input logic                rst,
  input logic                map_valid,
  input logic                map_ready,
  input cbsm_pkg::map_item_t map_data
);
  import cbsm_pkg::*;

  logic idle_zero;
  logic window_known;
  logic offset_aligned;

  assign idle_zero      = (map_data.window_base == '0) && (map_data.rom_offset == '0);
  assign window_known   = (map_data.window_base == SUPER_WIN_LO) ||
                          (map_data.window_base == ABS_WINDOW) ||
                          (map_data.window_base == ACT_WINDOW);
  assign offset_aligned = (map_data.rom_offset[BANK_SHIFT-1:0] == '0);

  `CBSM_ASSERT_NEXT(a_hold_valid, map_valid && !map_ready, map_valid, "result dropped")
  `CBSM_ASSERT_NOW(a_no_switch_zero, map_valid && !map_data.switched, idle_zero, "stray window")
  `CBSM_ASSERT_NOW(a_window_legal, map_valid && map_data.switched, window_known, "bad window")
  `CBSM_ASSERT_NOW(a_offset_aligned, map_valid, offset_aligned, "offset not bank aligned")
  `CBSM_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !map_valid, "valid right after reset")

endmodule

bind cartridge_bank_switch_mapper cbsm_checker u_cbsm_checker (
  .clk       (clk),
  .rst       (rst),
  .map_valid (mapping.valid),
  .map_ready (mapping.ready),
  .map_data  (mapping.data)
);

/* tb/cartridge_bank_switch_mapper_tb.sv */
// Self-checking testbench for the cartridge bank-switch mapper.
`timescale 1ns / 100ps

module cartridge_bank_switch_mapper_tb;
  import cbsm_pkg::*;

  localparam logic [TYPE_W-1:0] CART_UNUSED = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CART_TYPE = {REG_CART_TYPE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_ROM_BYTES = {REG_ROM_BYTES, 2'b00};
  localparam logic [ROM_W-1:0] ROM_FIELD_MAX = '1;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WRITES = 110;
  localparam int STALL_LIMIT = 200;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  cbsm_bus_if bus_write ();
  cbsm_map_if mapping ();

  cartridge_bank_switch_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .bus_write (bus_write),
    .mapping   (mapping),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the mapper's configuration and bank register.
  logic [TYPE_W-1:0] cart_mode = CART_PLAIN;
  logic [ROM_W-1:0] rom_setting = '0;
  logic [BANK_W-1:0] bank_shadow = '0;

  bus_item_t pending_writes[$];
  map_item_t predicted_maps[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int bus_gap = 0;
  int map_stall = 0;
  bit burst_mode = 1'b0;
  logic bus_taken;
  logic map_taken;

  always #2 clk = ~clk;

  function automatic map_item_t predict_mapping(bus_item_t wr);
    logic [ROM_W-1:0] size;
    logic [ROM_W-1:0] bank_limit;
    logic in_super;
    logic hit;
    logic small_rom;
    logic [BANK_W-1:0] bank;
    logic [BANK_W-1:0] ofs_bank;
    logic [ADDR_W-1:0] window;
    logic [31:0] offset;
    map_item_t res;
    size = (rom_setting > MAX_ROM_BYTES) ? MAX_ROM_BYTES : rom_setting;
    bank_limit = size >> BANK_SHIFT;
    in_super = wr.bus_address >= SUPER_WIN_LO && wr.bus_address < SUPER_WIN_HI &&
               wr.bus_data < bank_limit;
    hit = 1'b0;
    bank = '0;
    window = '0;
    case (cart_mode)
      CART_SUPER, CART_SUPER_RAM, CART_SUPER_ROM: begin
        if (in_super) begin
          hit = 1'b1;
          bank = wr.bus_data;
          window = SUPER_WIN_LO;
        end
      end
      CART_LARGE: begin
        if (in_super) begin
          hit = 1'b1;
          bank = wr.bus_data + 8'd1;
          window = SUPER_WIN_LO;
        end
      end
      CART_ABSOLUTE: begin
        if (wr.bus_address == SUPER_WIN_LO &&
            (wr.bus_data == ABS_BANK_A || wr.bus_data == ABS_BANK_B)) begin
          hit = 1'b1;
          bank = wr.bus_data - 8'd1;
          window = ABS_WINDOW;
        end
      end
      CART_ACTIVISION: begin
        if (wr.bus_address >= ACT_ADDR_LO) begin
          hit = 1'b1;
          bank = BANK_W'(wr.bus_address[2:0]);
          window = ACT_WINDOW;
        end
      end
      default: ;
    endcase
    // Small supercarts decode only two bank bits for the ROM offset.
    small_rom = (cart_mode == CART_SUPER || cart_mode == CART_SUPER_RAM ||
                 cart_mode == CART_SUPER_ROM) && size <= SMALL_ROM_LIMIT;
    ofs_bank = small_rom ? {6'b0, bank[1:0]} : bank;
    offset = 32'(ofs_bank) << BANK_SHIFT;
    res = '0;
    if (hit && offset < size) begin
      bank_shadow = bank;
      res.switched = 1'b1;
      res.window_base = window;
      res.rom_offset = offset[OFFSET_W-1:0];
    end
    res.current_bank = bank_shadow;
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Bus write driver.
  always @(negedge clk) begin
    if (rst) begin
      bus_write.valid <= 1'b0;
      bus_write.data <= '0;
      bus_gap = 0;
    end else begin
      if (bus_taken) bus_gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (bus_taken || !bus_write.valid) begin
        if (bus_gap == 0 && pending_writes.size() != 0) begin
          bus_write.valid <= 1'b1;
          bus_write.data <= pending_writes.pop_front();
        end else begin
          bus_write.valid <= 1'b0;
          if (bus_gap != 0) bus_gap--;
        end
      end
    end
  end

  // Result receiver: outside burst mode it may stall at random after each transaction.
  always @(negedge clk) begin
    if (rst) begin
      mapping.ready <= 1'b0;
      map_stall = 0;
    end else begin
      if (map_taken) map_stall = burst_mode ? 0 : $urandom_range(0, 3);
      if (map_stall != 0) begin
        mapping.ready <= 1'b0;
        map_stall--;
      end else begin
        mapping.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result before queueing the prediction of a new write.
  always @(posedge clk) begin : monitor
    map_item_t want;
    if (rst) begin
      bus_taken <= 1'b0;
      map_taken <= 1'b0;
    end else begin
      bus_taken <= bus_write.valid && bus_write.ready;
      map_taken <= mapping.valid && mapping.ready;
      if (mapping.valid && mapping.ready) begin
        if (predicted_maps.size() == 0) begin
          $display("%0t: unexpected mapping transaction, actual %0h", $time, mapping.data);
          mismatch_count++;
        end else begin
          want = predicted_maps.pop_front();
          check_field("switched", want.switched, mapping.data.switched);
          check_field("window_base", want.window_base, mapping.data.window_base);
          check_field("rom_offset", want.rom_offset, mapping.data.rom_offset);
          check_field("current_bank", want.current_bank, mapping.data.current_bank);
        end
      end
      if (bus_write.valid && bus_write.ready)
        predicted_maps.push_back(predict_mapping(bus_write.data));
    end
  end

  always @(posedge clk) begin
    if (rst || (bus_write.valid && bus_write.ready) || (mapping.valid && mapping.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Returns once the feed is empty and every predicted result has been checked.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_writes.size() != 0 || bus_write.valid) @(posedge clk);
    @(negedge clk);
    while (predicted_maps.size() != 0) @(negedge clk);
  endtask

  task automatic start_phase(logic [TYPE_W-1:0] mode, logic [ROM_W-1:0] rom, bit burst);
    wait_drained();
    apb_write(ADDR_CART_TYPE, CFG_DATA_W'(mode));
    apb_write(ADDR_ROM_BYTES, CFG_DATA_W'(rom));
    cart_mode = mode;
    rom_setting = rom;
    @(posedge clk);
    burst_mode = burst;
  endtask

  task automatic push_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    bus_item_t wr;
    wr.bus_address = addr;
    wr.bus_data = data;
    pending_writes.push_back(wr);
  endtask

  initial begin
    logic [ROM_W-1:0] rom;
    logic [ROM_W-1:0] bank_limit;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [TYPE_W-1:0] mode;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: a plain cartridge with no ROM never switches.
    push_write(16'h8000, 8'h00);
    push_write(16'hFFFF, 8'hFF);

    start_phase(CART_SUPER, ROM_W'(65536), 1'b0);
    push_write(16'h8000, 8'd0);
    push_write(16'hBFFF, 8'd3);
    push_write(16'hC000, 8'd1);
    push_write(16'h7FFF, 8'd1);
    push_write(16'h8000, 8'd4);

    // Large supercart: the bank past the end of the ROM is refused.
    start_phase(CART_LARGE, ROM_W'(131072), 1'b0);
    push_write(16'h8000, 8'd0);
    push_write(16'hA000, 8'd7);
    push_write(16'h9000, 8'd6);

    start_phase(CART_ABSOLUTE, ROM_W'(32768), 1'b1);
    push_write(16'h8000, 8'd1);
    push_write(16'h8000, 8'd2);
    push_write(16'h8000, 8'd0);
    push_write(16'h8000, 8'd3);
    push_write(16'h8001, 8'd1);

    start_phase(CART_ACTIVISION, MAX_ROM_BYTES, 1'b0);
    push_write(16'hFF80, 8'h5A);
    push_write(16'hFFFF, 8'hFF);
    push_write(16'hFF7F, 8'h00);

    // Oversized ROM counts as the largest supported size.
    start_phase(CART_SUPER_ROM, ROM_FIELD_MAX, 1'b0);
    push_write(16'h8000, 8'd63);
    push_write(16'h8000, 8'd64);
    push_write(16'hBFFF, 8'hFF);

    start_phase(CART_UNUSED, MAX_ROM_BYTES, 1'b0);
    push_write(16'hFF80, 8'd1);
    push_write(16'h8000, 8'd1);

    start_phase(CART_PLAIN, ROM_FIELD_MAX, 1'b0);
    push_write(16'h8000, 8'd0);
    push_write(16'hFFFF, 8'd2);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = (phase < 8) ? TYPE_W'(phase) : TYPE_W'($urandom_range(1, 6));
      case ($urandom_range(0, 5))
        0: rom = '0;
        1: rom = MAX_ROM_BYTES;
        2: rom = ROM_FIELD_MAX;
        3: rom = ROM_W'($urandom_range(1, 4) * BANK_BYTES);
        4: rom = ROM_W'($urandom_range(1, 64) * BANK_BYTES);
        default: rom = ROM_W'($urandom_range(0, ROM_FIELD_MAX));
      endcase
      start_phase(mode, rom, phase % 3 == 2);
      bank_limit = ((rom > MAX_ROM_BYTES) ? MAX_ROM_BYTES : rom) >> BANK_SHIFT;
      for (int n = 0; n < PHASE_WRITES; n++) begin
        // Once per run the feed stops until the mapper has delivered everything.
        if (phase == 4 && n == PHASE_WRITES / 2) begin
          wait_drained();
          @(posedge clk);
        end
        addr = ADDR_W'($urandom_range(0, 16'hFFFF));
        data = DATA_W'($urandom_range(0, 8'hFF));
        if ($urandom_range(0, 9) < 7) begin
          case (mode)
            CART_SUPER, CART_SUPER_RAM, CART_SUPER_ROM, CART_LARGE: begin
              addr = ADDR_W'($urandom_range(SUPER_WIN_LO, SUPER_WIN_HI - 1));
              data = DATA_W'($urandom_range(0, bank_limit + 1));
            end
            CART_ABSOLUTE: begin
              if ($urandom_range(0, 3) != 0) addr = SUPER_WIN_LO;
              data = DATA_W'($urandom_range(0, 3));
            end
            CART_ACTIVISION: addr = ADDR_W'($urandom_range(ACT_ADDR_LO, 16'hFFFF));
            default: ;
          endcase
        end
        push_write(addr, data);
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && predicted_maps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cbsm_pkg.sv
hdl/cbsm_if.sv
hdl/cbsm_cfg_regs.sv
hdl/cbsm_decode.sv
hdl/cartridge_bank_switch_mapper.sv
hdl/cbsm_checker.sv
tb/cartridge_bank_switch_mapper_tb.sv
